### sv/linear_scan_priority_queue_macros.svh
// Assertion macros for the linear scan priority queue.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LSPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LSPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/lspq_pkg.sv
// Package: sizes, codes and shared types of the linear scan priority queue.
package lspq_pkg;

    localparam int DEPTH        = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        addr;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_mem_wr;

    typedef struct packed {
        t_status                 status;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [CNT_W-1:0]        occupancy;
    } t_result;

endpackage

### sv/lspq_if.sv
// Channel interfaces: command input, result output and configuration write.
interface lspq_in_if import lspq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, output command, output key, output payload, input ready);
    modport sink   (input valid, input command, input key, input payload, output ready);
endinterface

interface lspq_out_if import lspq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [CNT_W-1:0]        occupancy;

    modport source (output valid, output status, output out_key, output out_payload,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_key, input out_payload,
                    input occupancy, output ready);
endinterface

interface lspq_cfg_if ();
    logic valid;
    logic ready;
    logic order_select;

    modport source (output valid, output order_select, input ready);
    modport sink   (input valid, input order_select, output ready);
endinterface

### sv/linear_scan_priority_queue.sv
// Top level: priority queue on an unsorted array, scanned one entry per cycle on pop.
// Push, pop on empty and push on full go from idle straight to the result state. No new item
// is taken until the result has gone to the output register. Pop: the scan walks the single
// read port one entry a cycle, then the last entry is fetched and moved into the winner's slot.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset empties the queue and selects smallest-first order.
`include "linear_scan_priority_queue_macros.svh"

module linear_scan_priority_queue import lspq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lspq_in_if.sink    i_in,
    lspq_out_if.source o_out,
    lspq_cfg_if.sink   i_cfg
);

    logic             r_order;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;
    t_mem_wr          w_wr;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
        end else if (i_cfg.valid) begin
            r_order <= i_cfg.order_select;
        end
    end

    lspq_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    lspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_order     (r_order),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_command   (i_in.command),
        .i_key       (i_in.key),
        .i_payload   (i_in.payload),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr        (w_wr),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    // Output register: load when empty or being drained.
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.out_key     = r_out.key;
    assign o_out.out_payload = r_out.payload;
    assign o_out.occupancy   = r_out.occupancy;

    `LSPQ_ASSERT_NEXT(a_busy_after_transfer, i_in.valid && i_in.ready, !i_in.ready, "input taken while an item is still in work")
    `LSPQ_ASSERT_SAME(a_empty_result, o_out.valid && (o_out.status == ST_EMPTY), (o_out.occupancy == '0) && (o_out.out_key == '0) && (o_out.out_payload == '0), "empty status with stored entries or data")
    `LSPQ_ASSERT_SAME(a_full_result, o_out.valid && (o_out.status == ST_FULL), o_out.occupancy == CNT_W'(DEPTH), "full status below capacity")

endmodule

### sv/lspq_mem.sv
// Entry store: one write port, one read port with registered read data.
module lspq_mem import lspq_pkg::*; (
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= '{key: i_wr.key, payload: i_wr.payload};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/lspq_ctrl.sv
// Sequencer: push append, pop scan with one shared key comparator, last-entry move.
module lspq_ctrl import lspq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_order,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_result                 o_res,
    output t_mem_wr                 o_wr,
    output logic [IDX_W-1:0]        o_rd_addr,
    input  t_entry                  i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_MOVE,
        S_RESULT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    t_entry           r_best, n_best;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    t_result          r_res, n_res;

    logic [CNT_W-1:0] w_cnt_m1;
    logic [CNT_W-1:0] w_cnt_p1;
    logic [IDX_W-1:0] w_last;
    logic             w_beats;
    logic             w_take;

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_cnt_p1 = r_count + CNT_W'(1);
    assign w_last   = w_cnt_m1[IDX_W-1:0];

    // Shared comparator: a later entry wins only on a strictly better key.
    assign w_beats = i_order ? (i_rd_data.key > r_best.key) : (i_rd_data.key < r_best.key);
    assign w_take  = r_pend && ((r_pend_idx == '0) || w_beats);

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_res      = r_res;
        o_rd_addr  = r_idx;
        o_wr       = '{we: 1'b0, addr: r_count[IDX_W-1:0], key: i_key, payload: i_payload};

        if (w_take && ((r_state == S_SCAN) || (r_state == S_LAST))) begin
            n_best     = i_rd_data;
            n_best_idx = r_pend_idx;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RESULT;
                    if (i_command == CMD_PUSH) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_res = '{status: ST_FULL, key: '0, payload: '0,
                                      occupancy: r_count};
                        end else begin
                            o_wr.we = 1'b1;
                            n_count = w_cnt_p1;
                            n_res   = '{status: ST_DONE, key: '0, payload: '0,
                                        occupancy: w_cnt_p1};
                        end
                    end else if (r_count == '0) begin
                        n_res = '{status: ST_EMPTY, key: '0, payload: '0,
                                  occupancy: r_count};
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle; compare the entry read the cycle before.
                o_rd_addr  = r_idx;
                n_pend     = 1'b1;
                n_pend_idx = r_idx;
                if (r_idx == w_last) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_LAST: begin
                // Compare the last entry and fetch it for the move.
                o_rd_addr = w_last;
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                o_wr    = '{we: 1'b1, addr: r_best_idx, key: i_rd_data.key,
                            payload: i_rd_data.payload};
                n_count = w_cnt_m1;
                n_res   = '{status: ST_DONE, key: r_best.key, payload: r_best.payload,
                            occupancy: w_cnt_m1};
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
    end

endmodule

### tb/linear_scan_priority_queue_tb.sv
// Self-checking testbench for the linear scan priority queue: directed and random traffic.
module linear_scan_priority_queue_tb import lspq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int SETTLE_CYCLES   = 80;
    localparam int QUIET_LIMIT     = 5000;

    // Tracks the queue contents and the result that each transfer must produce.
    class pq_tracker;
        logic [KEY_BITS-1:0]     key_slot[DEPTH];
        logic [PAYLOAD_BITS-1:0] payload_slot[DEPTH];
        int                      held;
        bit                      largest_first;
        t_result                 expected_results[$];
        int                      errors;

        function new();
            held          = 0;
            largest_first = 1'b0;
            errors        = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void set_order(bit largest);
            largest_first = largest;
        endfunction

        function void note_command(t_cmd cmd, logic [KEY_BITS-1:0] k,
                                   logic [PAYLOAD_BITS-1:0] p);
            t_result r;
            int      best;
            int      i;
            r.status  = ST_DONE;
            r.key     = '0;
            r.payload = '0;
            if (cmd == CMD_PUSH) begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    key_slot[held]     = k;
                    payload_slot[held] = p;
                    held++;
                end
            end else if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                // strictly better only, so the lowest slot wins a tie
                best = 0;
                for (i = 1; i < held; i++) begin
                    if (largest_first ? (key_slot[i] > key_slot[best])
                                      : (key_slot[i] < key_slot[best]))
                        best = i;
                end
                r.key     = key_slot[best];
                r.payload = payload_slot[best];
                key_slot[best]     = key_slot[held-1];
                payload_slot[best] = payload_slot[held-1];
                held--;
            end
            r.occupancy = CNT_W'(held);
            expected_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d key %h payload %h occ %0d",
                         $time, got.status, got.key, got.payload, got.occupancy);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.key !== want.key) begin
                $display("%0t: out_key mismatch: expected %h actual %h",
                         $time, want.key, got.key);
                errors++;
            end
            if (got.payload !== want.payload) begin
                $display("%0t: out_payload mismatch: expected %h actual %h",
                         $time, want.payload, got.payload);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy mismatch: expected %0d actual %0d",
                         $time, want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lspq_in_if  in_ch ();
    lspq_out_if out_ch ();
    lspq_cfg_if cfg_ch ();

    linear_scan_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pq_tracker tracker = new();
    int        send_idle_pct;
    int        recv_stall_pct;
    int        quiet_cycles;
    int        sent_count;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_PUSH;
        in_ch.key           = '0;
        in_ch.payload       = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.order_select = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        quiet_cycles        = 0;
        sent_count          = 0;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Sample every channel at the rising edge; feed the tracker.
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tracker.note_command(t_cmd'(in_ch.command), in_ch.key, in_ch.payload);
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.status    = t_status'(out_ch.status);
                got.key       = out_ch.out_key;
                got.payload   = out_ch.out_payload;
                got.occupancy = out_ch.occupancy;
                tracker.check_result(got);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                tracker.set_order(cfg_ch.order_select);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_BITS'($urandom_range(0, 3));
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    // Enter at a falling edge; return at the falling edge after the transfer.
    task automatic send_item(t_cmd cmd, logic [KEY_BITS-1:0] k, logic [PAYLOAD_BITS-1:0] p);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_ch.valid   = 1'b1;
        in_ch.command = cmd;
        in_ch.key     = k;
        in_ch.payload = p;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_random(t_cmd cmd);
        send_item(cmd, pick_key(), PAYLOAD_BITS'($urandom));
    endtask

    // Drain the queue of results, let the block settle, then write the order.
    task automatic write_order(bit largest);
        in_ch.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.valid        = 1'b1;
        cfg_ch.order_select = largest;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        int push_pct;
        int ph;
        idle_tab  = '{0, 86, 0, 6};
        stall_tab = '{0, 0, 86, 6};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_order(1'b0);
        send_item(CMD_POP,  16'h0000, 16'h0000);
        send_item(CMD_PUSH, 16'h0000, 16'hFFFF);
        send_item(CMD_PUSH, 16'hFFFF, 16'h0000);
        send_item(CMD_PUSH, 16'h8000, 16'h1234);
        send_item(CMD_PUSH, 16'h7FFF, 16'hAAAA);
        send_item(CMD_PUSH, 16'h7FFF, 16'h5555);
        send_item(CMD_PUSH, 16'h0000, 16'h0F0F);
        repeat (6) send_item(CMD_POP, 16'hFFFF, 16'hFFFF);
        send_item(CMD_POP,  16'hFFFF, 16'hFFFF);

        for (ph = 0; ph < 4; ph++) begin
            write_order(ph % 2 == 0);
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            sent_count     = 0;
            while (sent_count < ITEMS_PER_PHASE) begin
                case ($urandom_range(0, 7))
                    0: begin
                        // fill to the top, then overflow
                        while (tracker.held < DEPTH) send_random(CMD_PUSH);
                        repeat ($urandom_range(1, 3)) send_random(CMD_PUSH);
                    end
                    1: begin
                        while (tracker.held > 0) send_random(CMD_POP);
                        repeat ($urandom_range(1, 2)) send_random(CMD_POP);
                    end
                    default: begin
                        push_pct = $urandom_range(30, 70);
                        repeat ($urandom_range(4, 20)) begin
                            if ($urandom_range(0, 99) < push_pct)
                                send_random(CMD_PUSH);
                            else
                                send_random(CMD_POP);
                        end
                    end
                endcase
            end
        end

        in_ch.valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
